/* sv/gpq_pkg.sv */
// ----------------------------------------------------------------------------
// gpq_pkg
// shared constants, types and helpers of the gamepad event qualifier
// ----------------------------------------------------------------------------
package gpq_pkg;

  localparam int MAX_PADS    = 8;
  localparam int NUM_BUTTONS = 21;
  localparam int NUM_AXES    = 6;
  localparam int NUM_STICKS  = NUM_AXES - 2;
  localparam int NUM_EVENTS  = NUM_BUTTONS + NUM_AXES;

  localparam int PAD_W       = 3;
  localparam int CODE_W      = 5;
  localparam int AXIS_W      = 16;
  localparam int DIFF_W      = 16;
  localparam int THR_W       = 15;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int AX_IDX_W    = $clog2(NUM_AXES);
  localparam int EV_IDX_W    = $clog2(NUM_EVENTS);
  localparam int AXIS_DEPTH  = MAX_PADS * NUM_AXES;
  localparam int AXIS_ADDR_W = $clog2(AXIS_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_THR  = 1'd1;

  localparam logic [DIFF_W-1:0] MIN_DIFF_RESET = 16'd1638;
  localparam logic [THR_W-1:0]  ACK_THR_RESET  = 15'd16384;

  typedef struct packed {
    logic                     fire;
    logic                     pressed;
    logic [CODE_W-1:0]        code;
    logic signed [AXIS_W-1:0] wdata;
  } axis_eval_t;

  function automatic logic [AXIS_ADDR_W-1:0] axis_addr(input logic [PAD_W-1:0] pad,
                                                       input logic [AX_IDX_W-1:0] idx);
    axis_addr = AXIS_ADDR_W'(pad) * AXIS_ADDR_W'(NUM_AXES) + AXIS_ADDR_W'(idx);
  endfunction

endpackage

/* sv/gamepad_event_qualifier.sv */
// ----------------------------------------------------------------------------
// gamepad_event_qualifier
// turns polled gamepad snapshots into button, stick and trigger events
// ----------------------------------------------------------------------------
// flow: a snapshot steps through its six axes in S_AXIS, then S_EMIT sends
//   its N events (N <= 27); a new snapshot is taken only once all are sent,
//   and a disconnect snapshot raises none; paced by the single axis memory
//   read port (one axis a cycle) and one event word a cycle at the output while not stalled
// reset: synchronous, clears presence bits, registers to defaults, no event
// ----------------------------------------------------------------------------
module gamepad_event_qualifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpq_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              snap_valid,
  output logic                              snap_ready,
  input  logic [gpq_pkg::PAD_W-1:0]         pad_index,
  input  logic                              connected,
  input  logic                              identity_changed,
  input  logic [gpq_pkg::NUM_BUTTONS-1:0]   buttons,
  input  logic signed [gpq_pkg::AXIS_W-1:0] left_x,
  input  logic signed [gpq_pkg::AXIS_W-1:0] left_y,
  input  logic signed [gpq_pkg::AXIS_W-1:0] right_x,
  input  logic signed [gpq_pkg::AXIS_W-1:0] right_y,
  input  logic signed [gpq_pkg::AXIS_W-1:0] trigger_left,
  input  logic signed [gpq_pkg::AXIS_W-1:0] trigger_right,
  output logic                              event_valid,
  input  logic                              event_ready,
  output logic [gpq_pkg::PAD_W-1:0]         event_pad,
  output logic [gpq_pkg::CODE_W-1:0]        event_code,
  output logic                              pressed,
  output logic                              last_event
);
  import gpq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_AXIS, S_EMIT} state_t;

  state_t                   state;
  logic [DIFF_W-1:0]        min_difference;
  logic [THR_W-1:0]         acknowledge_threshold;
  logic [MAX_PADS-1:0]      pad_present;
  logic [PAD_W-1:0]         pad_r;
  logic                     fresh;
  logic [NUM_BUTTONS-1:0]   buttons_r;
  logic signed [AXIS_W-1:0] axis_r [NUM_AXES];
  logic [AX_IDX_W-1:0]      ax_proc;
  logic [NUM_EVENTS-1:0]    pend;
  logic [CODE_W-1:0]        ev_code [NUM_AXES];
  logic [NUM_AXES-1:0]      ev_pr;

  logic                     snap_take;
  logic [AX_IDX_W-1:0]      rd_idx;
  logic [AXIS_ADDR_W-1:0]   axis_raddr, axis_waddr;
  logic [AXIS_W-1:0]        axis_rdata;
  logic [NUM_BUTTONS-1:0]   btn_rdata, btn_old;
  logic                     btn_we, axis_we;
  logic signed [AXIS_W-1:0] old_value;
  axis_eval_t               eval;

  logic [EV_IDX_W-1:0]      pick;
  logic [NUM_EVENTS-1:0]    pick_hot;
  logic [CODE_W-1:0]        code_all [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]    pr_all;
  logic                     out_free;
  logic                     ev_load;

  assign snap_ready = (state == S_IDLE);
  assign snap_take  = snap_valid && snap_ready;
  assign out_free   = !event_valid || event_ready;
  assign ev_load    = (state == S_EMIT) && (pend != '0) && out_free;

  // memory addressing
  assign rd_idx     = (ax_proc == AX_IDX_W'(NUM_AXES - 1)) ? ax_proc : ax_proc + 1'b1;
  assign axis_raddr = (state == S_IDLE) ? axis_addr(pad_index, '0) : axis_addr(pad_r, rd_idx);
  assign axis_waddr = axis_addr(pad_r, ax_proc);
  assign axis_we    = (state == S_AXIS);
  assign btn_we     = (state == S_AXIS) && (ax_proc == '0);
  assign btn_old    = fresh ? '0 : btn_rdata;
  assign old_value  = fresh ? '0 : $signed(axis_rdata);

  gpq_ram #(.WIDTH(NUM_BUTTONS), .DEPTH(MAX_PADS)) u_btn_ram (
    .clk   (clk),
    .we    (btn_we),
    .waddr (pad_r),
    .wdata (buttons_r),
    .raddr (pad_index),
    .rdata (btn_rdata)
  );

  gpq_ram #(.WIDTH(AXIS_W), .DEPTH(AXIS_DEPTH)) u_axis_ram (
    .clk   (clk),
    .we    (axis_we),
    .waddr (axis_waddr),
    .wdata (eval.wdata),
    .raddr (axis_raddr),
    .rdata (axis_rdata)
  );

  gpq_axis_eval u_axis_eval (
    .axis_sel              (ax_proc),
    .old_value             (old_value),
    .new_value             (axis_r[ax_proc]),
    .min_difference        (min_difference),
    .acknowledge_threshold (acknowledge_threshold),
    .result                (eval)
  );

  // event table and lowest pending pick
  always_comb begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      code_all[k] = CODE_W'(k);
      pr_all[k]   = buttons_r[k];
    end
    for (int j = 0; j < NUM_AXES; j++) begin
      code_all[NUM_BUTTONS+j] = ev_code[j];
      pr_all[NUM_BUTTONS+j]   = ev_pr[j];
    end
    pick = '0;
    for (int k = NUM_EVENTS - 1; k >= 0; k--) begin
      if (pend[k]) begin
        pick = EV_IDX_W'(k);
      end
    end
    pick_hot = NUM_EVENTS'(1) << pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      min_difference        <= MIN_DIFF_RESET;
      acknowledge_threshold <= ACK_THR_RESET;
      pad_present           <= '0;
      event_valid           <= 1'b0;
      ax_proc               <= '0;
      pend                  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MIN_DIFF: min_difference <= cfg_data;
          REG_ACK_THR:  acknowledge_threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end

      if (ev_load) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (snap_take) begin
            pad_r                  <= pad_index;
            fresh                  <= !pad_present[pad_index] || identity_changed;
            pad_present[pad_index] <= connected;
            buttons_r              <= buttons;
            axis_r[0]              <= left_x;
            axis_r[1]              <= left_y;
            axis_r[2]              <= right_x;
            axis_r[3]              <= right_y;
            axis_r[4]              <= trigger_left;
            axis_r[5]              <= trigger_right;
            ax_proc                <= '0;
            pend                   <= '0;
            if (connected) begin
              state <= S_AXIS;
            end
          end
        end
        S_AXIS: begin
          if (ax_proc == '0) begin
            pend <= {{(NUM_AXES-1){1'b0}}, eval.fire, buttons_r ^ btn_old};
          end else begin
            pend[EV_IDX_W'(NUM_BUTTONS) + EV_IDX_W'(ax_proc)] <= eval.fire;
          end
          ev_code[ax_proc] <= eval.code;
          ev_pr[ax_proc]   <= eval.pressed;
          if (ax_proc == AX_IDX_W'(NUM_AXES - 1)) begin
            state <= S_EMIT;
          end else begin
            ax_proc <= ax_proc + 1'b1;
          end
        end
        S_EMIT: begin
          if (pend == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            event_pad   <= pad_r;
            event_code  <= code_all[pick];
            pressed     <= pr_all[pick];
            last_event  <= (pend & ~pick_hot) == '0;
            pend        <= pend & ~pick_hot;
            if ((pend & ~pick_hot) == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/gpq_ram.sv */
// ----------------------------------------------------------------------------
// gpq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gpq_axis_eval.sv */
// ----------------------------------------------------------------------------
// gpq_axis_eval
// dead band check and, for sticks, threshold crossing decision for one axis
// ----------------------------------------------------------------------------
module gpq_axis_eval (
  input  logic [gpq_pkg::AX_IDX_W-1:0]      axis_sel,
  input  logic signed [gpq_pkg::AXIS_W-1:0] old_value,
  input  logic signed [gpq_pkg::AXIS_W-1:0] new_value,
  input  logic [gpq_pkg::DIFF_W-1:0]        min_difference,
  input  logic [gpq_pkg::THR_W-1:0]         acknowledge_threshold,
  output gpq_pkg::axis_eval_t               result
);
  import gpq_pkg::*;

  logic signed [AXIS_W:0] old_x, new_x, diff, mag, thr, nthr;
  logic                   qual, stick;
  logic                   pos_press, pos_rel, neg_press, neg_rel, neg;

  always_comb begin
    old_x = (AXIS_W+1)'(old_value);
    new_x = (AXIS_W+1)'(new_value);
    diff  = new_x - old_x;
    mag   = diff[AXIS_W] ? -diff : diff;
    qual  = $unsigned(mag) > (AXIS_W+1)'(min_difference);
    thr   = $signed((AXIS_W+1)'(acknowledge_threshold));
    nthr  = -thr;
    stick = axis_sel < AX_IDX_W'(NUM_STICKS);

    pos_press = (old_x < thr) && (new_x >= thr);
    pos_rel   = (old_x >= thr) && (new_x < thr);
    neg_press = (old_x > nthr) && (new_x <= nthr);
    neg_rel   = (old_x <= nthr) && (new_x > nthr);
    neg       = !pos_press && !pos_rel;

    result.wdata = qual ? new_value : old_value;
    if (stick) begin
      result.fire    = qual && (pos_press || pos_rel || neg_press || neg_rel);
      result.pressed = pos_press || (!pos_rel && neg_press);
      result.code    = CODE_W'(NUM_BUTTONS) + (CODE_W'(axis_sel) << 1) + CODE_W'(neg);
    end else begin
      result.fire    = qual;
      result.pressed = new_x > old_x;
      result.code    = CODE_W'(NUM_BUTTONS + NUM_STICKS) + CODE_W'(axis_sel);
    end
  end

endmodule

/* sv/gpq_checker.sv */
// ----------------------------------------------------------------------------
// gpq_checker
// port level checks of the gamepad event qualifier, bound to the top level
// ----------------------------------------------------------------------------
module gpq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              snap_valid,
  input logic                              snap_ready,
  input logic                              connected,
  input logic                              event_valid,
  input logic                              event_ready,
  input logic [gpq_pkg::PAD_W-1:0]         event_pad,
  input logic [gpq_pkg::CODE_W-1:0]        event_code,
  input logic                              pressed,
  input logic                              last_event
);

  // stalled event word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=>
      event_valid && $stable(event_code) && $stable(event_pad) && $stable(pressed))
    else $error("event word changed while stalled");

  // no snapshot taken while a snapshot still has events to send
  a_busy: assert property (@(posedge clk) disable iff (rst)
    event_valid && !last_event |-> !snap_ready)
    else $error("snapshot accepted mid event burst");

  // the next word of a burst follows at once, for the same pad
  a_burst: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready && !last_event |=>
      event_valid && event_pad == $past(event_pad))
    else $error("event burst broken");

  // a disconnect snapshot raises no event
  a_disc: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_ready && !connected && (!event_valid || event_ready) |=> !event_valid)
    else $error("event after disconnect snapshot");

endmodule

bind gamepad_event_qualifier gpq_checker u_gpq_checker (.*);
